@@ hw/rtl/udm_pkg.sv @@
// ----------------------------------------------------------------------------
// udm_pkg
// Shared widths and types for the 64-bit unsigned divide/modulo block.
// ----------------------------------------------------------------------------
package udm_pkg;

	// Width of the operand and result fields on the channels.
	localparam int unsigned WORD_W = 64;

	typedef logic [WORD_W-1:0] word_t;

	// Sequencer commands to the datapath.
	typedef struct packed {
		logic load;    // take a new operand beat
		logic step;    // run one compare/subtract/shift iteration
		logic finish;  // last iteration; write the result register
	} ctl_t;

endpackage

@@ hw/rtl/udm_ifs.sv @@
// ----------------------------------------------------------------------------
// udm_ifs
// Valid/ready channel interfaces for operand and result beats.
// ----------------------------------------------------------------------------
interface udm_req_if;
	logic            valid;
	logic            ready;
	udm_pkg::word_t  dividend;
	udm_pkg::word_t  divisor;

	modport source (output valid, output dividend, output divisor, input ready);
	modport sink   (input valid, input dividend, input divisor, output ready);
endinterface

interface udm_rsp_if;
	logic            valid;
	logic            ready;
	udm_pkg::word_t  quotient;
	udm_pkg::word_t  remainder;
	logic            divide_by_zero;

	modport source (output valid, output quotient, output remainder,
		output divide_by_zero, input ready);
	modport sink   (input valid, input quotient, input remainder,
		input divide_by_zero, output ready);
endinterface

@@ hw/rtl/udm_step.sv @@
// ----------------------------------------------------------------------------
// udm_step
// One restoring-division iteration: shift in the next dividend bit, trial
// subtract the divisor, keep the difference when it does not borrow.
// ----------------------------------------------------------------------------
module udm_step #(
	parameter int unsigned DATA_WIDTH = 64
) (
	input  logic [DATA_WIDTH-1:0] rem,
	input  logic [DATA_WIDTH-1:0] quo,
	input  logic [DATA_WIDTH-1:0] den,
	output logic [DATA_WIDTH-1:0] rem_nxt,
	output logic [DATA_WIDTH-1:0] quo_nxt
);

	logic [DATA_WIDTH:0]   shifted;
	logic [DATA_WIDTH+1:0] diff;
	logic                  fits;

	// quo holds the unconsumed dividend bits in its top; quotient bits enter at the bottom
	assign shifted = {rem, quo[DATA_WIDTH-1]};
	assign diff    = {1'b0, shifted} - {2'b00, den};
	assign fits    = ~diff[DATA_WIDTH+1];

	// partial remainder stays below den, so the low bits are enough
	assign rem_nxt = fits ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
	assign quo_nxt = {quo[DATA_WIDTH-2:0], fits};

endmodule

@@ hw/rtl/udm_ctrl.sv @@
// ----------------------------------------------------------------------------
// udm_ctrl
// Sequencer: takes an operand beat, counts DATA_WIDTH iterations, and holds
// the last one until the result register is free.
// ----------------------------------------------------------------------------
module udm_ctrl #(
	parameter int unsigned DATA_WIDTH = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic          rsp_free,
	output logic          req_ready,
	output udm_pkg::ctl_t ctl
);

	localparam int unsigned CNT_W = $clog2(DATA_WIDTH);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic             state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             last;

	assign last      = (cnt_q == '0);
	assign req_ready = (state_q == ST_IDLE);

	assign ctl.load   = req_ready & req_valid;
	assign ctl.step   = (state_q == ST_RUN) & (~last | rsp_free);
	assign ctl.finish = (state_q == ST_RUN) & last & rsp_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= ST_RUN;
						cnt_q   <= CNT_W'(DATA_WIDTH - 1);
					end
				end
				ST_RUN: begin
					if (ctl.step) begin
						if (last) begin
							state_q <= ST_IDLE;
						end else begin
							cnt_q <= cnt_q - CNT_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ hw/rtl/unsigned_divmod_64_top.sv @@
// ----------------------------------------------------------------------------
// unsigned_divmod_64_top
// Restoring unsigned divider giving quotient and remainder of one operand
// beat, one quotient bit per cycle through a shared compare/subtract unit.
// ----------------------------------------------------------------------------
// channel | dir | payload                                   | handshake
// req     | in  | dividend[63:0], divisor[63:0]             | valid/ready
// rsp     | out | quotient[63:0], remainder[63:0], div-by-0 | valid/ready
//
// Each operand beat is loaded when taken, then its quotient bits are formed
// one per cycle through the shared subtract/compare unit. Result valid and
// req.ready rise together after the last iteration; a waiting result holds
// the last iteration and so blocks the next operand beat.
// A stalled result holds the last iteration until the result register frees.
// Reset clears only control state; operand bits above DATA_WIDTH are ignored.
// ----------------------------------------------------------------------------
module unsigned_divmod_64_top #(
	parameter int unsigned DATA_WIDTH = 64
) (
	input logic      clk,
	input logic      arst_n,
	udm_req_if.sink   req,
	udm_rsp_if.source rsp
);

	localparam int unsigned W = DATA_WIDTH;

	udm_pkg::ctl_t  ctl;
	logic           rsp_free;

	logic [W-1:0]   rem_q;
	logic [W-1:0]   quo_q;
	logic [W-1:0]   den_q;
	logic           dbz_q;
	logic [W-1:0]   rem_nxt;
	logic [W-1:0]   quo_nxt;

	logic           rsp_valid_q;
	udm_pkg::word_t quotient_q;
	udm_pkg::word_t remainder_q;
	logic           dbz_out_q;

	assign rsp_free = ~rsp_valid_q | rsp.ready;

	udm_ctrl #(
		.DATA_WIDTH(W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.rsp_free  (rsp_free),
		.req_ready (req.ready),
		.ctl       (ctl)
	);

	udm_step #(
		.DATA_WIDTH(W)
	) u_step (
		.rem     (rem_q),
		.quo     (quo_q),
		.den     (den_q),
		.rem_nxt (rem_nxt),
		.quo_nxt (quo_nxt)
	);

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			rem_q <= '0;
			quo_q <= req.dividend[W-1:0];
			den_q <= req.divisor[W-1:0];
			dbz_q <= (req.divisor[W-1:0] == '0);
		end else if (ctl.step) begin
			rem_q <= rem_nxt;
			quo_q <= quo_nxt;
		end
	end

	// with a zero divisor every trial subtract fits: all-ones quotient,
	// remainder equal to the dividend
	always_ff @(posedge clk) begin
		if (ctl.finish) begin
			quotient_q  <= udm_pkg::WORD_W'(quo_nxt);
			remainder_q <= udm_pkg::WORD_W'(rem_nxt);
			dbz_out_q   <= dbz_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctl.finish) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.quotient       = quotient_q;
	assign rsp.remainder      = remainder_q;
	assign rsp.divide_by_zero = dbz_out_q;

	// A taken operand beat makes the block busy in the next cycle.
	a_busy_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("divider ready right after taking an operand beat");

	// Partial remainder stays below a nonzero divisor while iterating.
	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready && den_q != '0 |-> rem_q < den_q)
		else $error("partial remainder not below divisor");

	// A result is written only into a free result register.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.finish |-> rsp_free)
		else $error("result written over an unaccepted beat");

	// Divide by zero reports an all-ones quotient within DATA_WIDTH bits.
	a_dbz_quotient: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.divide_by_zero |->
			rsp.quotient == udm_pkg::WORD_W'({W{1'b1}}))
		else $error("divide by zero without all-ones quotient");

endmodule

@@ bench/tb_unsigned_divmod_64_top.sv @@
// ----------------------------------------------------------------------------
// tb_unsigned_divmod_64_top
// Self-checking bench for the 64-bit restoring divider. It walks a table of
// corner operands, then sends random operand beats shaped to exercise varied
// leading-zero counts, zero divisors and dividends below the divisor. Each
// result beat is checked in order against a bit-level restoring-division
// predictor, or against a typed-in answer for the typed corner rows.
// ----------------------------------------------------------------------------
module tb_unsigned_divmod_64_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned    DATA_WIDTH = 64;
	localparam udm_pkg::word_t WMASK      = udm_pkg::word_t'({DATA_WIDTH{1'b1}});
	localparam udm_pkg::word_t ONES       = '1;
	localparam udm_pkg::word_t TOP        = 64'h8000_0000_0000_0000;
	localparam int             RAND_BEATS = 1280;
	localparam int             QUIET_FROM = 1130;   // no idling past this beat
	localparam int             LONG_HOLD  = 400;    // receiver hold-off, cycles
	localparam int             HOLD_AFTER = 150;    // results seen before hold-off
	localparam int             DRAIN      = 80;
	localparam int             WDOG_LIMIT = 4000;

	typedef struct packed {
		udm_pkg::word_t quotient;
		udm_pkg::word_t remainder;
		logic           divide_by_zero;
	} divres_t;

	typedef struct packed {
		udm_pkg::word_t dividend;
		udm_pkg::word_t divisor;
		bit             typed;      // want is valid; otherwise use the predictor
		divres_t        want;
	} div_row_t;

	localparam int N_ROWS = 21;
	localparam div_row_t CORNER_ROWS [N_ROWS] = '{
		'{64'd0,            64'd0,        1'b1, '{ONES, 64'd0, 1'b1}},
		'{ONES,             64'd0,        1'b1, '{ONES, ONES, 1'b1}},
		'{64'd1234,         64'd0,        1'b1, '{ONES, 64'd1234, 1'b1}},
		'{64'd0,            64'd1,        1'b1, '{64'd0, 64'd0, 1'b0}},
		'{ONES,             64'd1,        1'b1, '{ONES, 64'd0, 1'b0}},
		'{ONES,             ONES,         1'b1, '{64'd1, 64'd0, 1'b0}},
		'{64'd0,            ONES,         1'b1, '{64'd0, 64'd0, 1'b0}},
		'{64'd1,            ONES,         1'b1, '{64'd0, 64'd1, 1'b0}},
		'{ONES - 64'd1,     ONES,         1'b1, '{64'd0, ONES - 64'd1, 1'b0}},
		'{TOP,              TOP,          1'b1, '{64'd1, 64'd0, 1'b0}},
		'{ONES,             TOP,          1'b1, '{64'd1, TOP - 64'd1, 1'b0}},
		'{ONES,             64'd2,        1'b1, '{ONES >> 1, 64'd1, 1'b0}},
		'{TOP,              64'd1,        1'b1, '{TOP, 64'd0, 1'b0}},
		'{64'd100,          64'd7,        1'b0, '0},
		'{64'd5,            64'd3,        1'b0, '0},
		'{64'd3,            64'd5,        1'b0, '0},
		'{64'hdead_beef_cafe_f00d, 64'h1234, 1'b0, '0},
		'{64'h0123_4567_89ab_cdef, 64'h0000_0001_0000_0003, 1'b0, '0},
		'{64'hffff_0000_ffff_0000, 64'h0000_ffff_0000_ffff, 1'b0, '0},
		'{64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 1'b0, '0},
		'{ONES,             64'h1_0000_0001, 1'b0, '0}
	};

	logic clk = 1'b0;
	logic arst_n;

	udm_req_if req_ch ();
	udm_rsp_if rsp_ch ();

	unsigned_divmod_64_top #(.DATA_WIDTH(DATA_WIDTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #1 clk = ~clk;

	divres_t pending_q [$];
	int      err_count  = 0;
	int      rsp_count  = 0;
	bit      quiet      = 1'b0;
	bit      long_done  = 1'b0;
	int      hold_cnt   = 0;
	int      stale_cyc  = 0;

	// Restoring division: normalize the divisor, then one compare/subtract
	// per quotient bit from the top weight down.
	function automatic divres_t restoring_divide(udm_pkg::word_t a, udm_pkg::word_t b);
		divres_t        res;
		udm_pkg::word_t rem;
		udm_pkg::word_t den;
		udm_pkg::word_t quo;
		int unsigned    lz;
		int unsigned    stp;
		rem = a & WMASK;
		den = b & WMASK;
		quo = '0;
		if (den == '0) begin
			res.quotient       = WMASK;
			res.remainder      = rem;
			res.divide_by_zero = 1'b1;
			return res;
		end
		lz = 0;
		while (!den[DATA_WIDTH-1-lz])
			lz++;
		den = (den << lz) & WMASK;
		for (stp = 0; stp <= lz; stp++) begin
			if (rem >= den) begin
				rem = rem - den;
				quo[lz-stp] = 1'b1;
			end
			den = den >> 1;
		end
		res.quotient       = quo & WMASK;
		res.remainder      = rem & WMASK;
		res.divide_by_zero = 1'b0;
		return res;
	endfunction

	function automatic udm_pkg::word_t rand_word();
		return {$urandom, $urandom};
	endfunction

	task automatic report_mismatch(string field, udm_pkg::word_t got,
		udm_pkg::word_t want);
		$display("%0t mismatch on %s: got %h want %h", $realtime, field, got, want);
		err_count++;
	endtask

	// Offer one operand beat; valid stays up into the next beat unless
	// an idle burst is drawn.
	task automatic send_beat(udm_pkg::word_t a, udm_pkg::word_t b, divres_t want);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.dividend <= a;
		req_ch.divisor  <= b;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		pending_q.push_back(want);
	endtask

	// Result receiver: random stalls plus one long hold-off to back up the block.
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			hold_cnt     <= 0;
		end else if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
			if (hold_cnt == 1)
				rsp_ch.ready <= 1'b1;
		end else if (!long_done && rsp_count >= HOLD_AFTER) begin
			long_done    <= 1'b1;
			rsp_ch.ready <= 1'b0;
			hold_cnt     <= LONG_HOLD;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			rsp_ch.ready <= 1'b0;
			hold_cnt     <= $urandom_range(1, 16);
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	// Result checker
	always @(posedge clk) begin
		divres_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			rsp_count <= rsp_count + 1;
			if (pending_q.size() == 0) begin
				$display("%0t result beat with nothing pending: q=%h r=%h dz=%b",
					$realtime, rsp_ch.quotient, rsp_ch.remainder, rsp_ch.divide_by_zero);
				err_count++;
			end else begin
				want = pending_q.pop_front();
				if (rsp_ch.quotient !== want.quotient)
					report_mismatch("quotient", rsp_ch.quotient, want.quotient);
				if (rsp_ch.remainder !== want.remainder)
					report_mismatch("remainder", rsp_ch.remainder, want.remainder);
				if (rsp_ch.divide_by_zero !== want.divide_by_zero)
					report_mismatch("divide_by_zero",
						udm_pkg::word_t'(rsp_ch.divide_by_zero),
						udm_pkg::word_t'(want.divide_by_zero));
			end
		end
	end

	// Watchdog on cycles with no beat on either channel
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			stale_cyc <= 0;
		else
			stale_cyc <= stale_cyc + 1;
		if (stale_cyc >= WDOG_LIMIT) begin
			$display("%0t watchdog: no beat for %0d cycles", $realtime, stale_cyc);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		udm_pkg::word_t a;
		udm_pkg::word_t b;
		divres_t        want;
		int             i;
		arst_n          = 1'b0;
		req_ch.valid    = 1'b0;
		req_ch.dividend = '0;
		req_ch.divisor  = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < N_ROWS; i++) begin
			a = CORNER_ROWS[i].dividend;
			b = CORNER_ROWS[i].divisor;
			want = CORNER_ROWS[i].typed ? CORNER_ROWS[i].want : restoring_divide(a, b);
			send_beat(a, b, want);
		end

		for (i = 0; i < RAND_BEATS; i++) begin
			if (i >= QUIET_FROM)
				quiet = 1'b1;
			a = rand_word();
			b = rand_word();
			case ($urandom_range(0, 9))
				0: b = '0;
				1: b = udm_pkg::word_t'($urandom_range(1, 15));
				2, 3: b = b >> $urandom_range(0, DATA_WIDTH - 1);
				4: b = a;
				5: a = a >> $urandom_range(1, DATA_WIDTH - 1);
				default: begin
					a = a >> $urandom_range(0, DATA_WIDTH / 2);
					b = b >> $urandom_range(0, DATA_WIDTH - 1);
				end
			endcase
			send_beat(a, b, restoring_divide(a, b));
		end
		req_ch.valid <= 1'b0;

		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);

		if (err_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/udm_pkg.sv
hw/rtl/udm_ifs.sv
hw/rtl/udm_step.sv
hw/rtl/udm_ctrl.sv
hw/rtl/unsigned_divmod_64_top.sv
bench/tb_unsigned_divmod_64_top.sv
